// ===== rtl/ujse_pkg.sv =====
// Package for the UTF-8 to JSON string escaper: shared widths, emit modes,
// the hex digit lookup, UTF-8 lead byte decoding and the escape classifier.
// No dependencies.
package ujse_pkg;

	localparam int unsigned MAX_SEQ_BYTES_DEF = 7;
	localparam int unsigned CNT_W             = 3;
	localparam int unsigned CODE_W            = 21;
	localparam logic [CODE_W-1:0] CODE_CAP    = 21'h110000;

	typedef logic [1:0] emit_mode_t;
	localparam emit_mode_t EM_PLAIN = 2'd0;
	localparam emit_mode_t EM_ESC   = 2'd1;
	localparam emit_mode_t EM_UNI   = 2'd2;

	// How one decoded value is turned into characters
	typedef struct packed {
		emit_mode_t  mode;
		logic        two;    // surrogate pair: second word follows
		logic [31:0] words;  // first word in the top half
		logic [7:0]  chr;    // plain character or escape letter
	} emit_load_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10)
			r = 8'h30 + {4'd0, n};
		else
			r = 8'h57 + {4'd0, n};
		return r;
	endfunction

	// Full length of a sequence from its lead byte; 1 means a lone byte
	function automatic logic [CNT_W-1:0] seq_len(input logic [7:0] b,
		input int unsigned max_len);
		logic [CNT_W-1:0] len;
		if (b < 8'hC0 || b == 8'hFF)
			len = 3'd1;
		else if (b < 8'hE0)
			len = 3'd2;
		else if (b < 8'hF0)
			len = 3'd3;
		else if (b < 8'hF8)
			len = 3'd4;
		else if (b < 8'hFC)
			len = 3'd5;
		else if (b < 8'hFE)
			len = 3'd6;
		else
			len = 3'd7;
		if (int'(len) > max_len)
			len = 3'd1;
		return len;
	endfunction

	function automatic emit_load_t code_load(input logic [CODE_W-1:0] v);
		emit_load_t        r;
		logic [CODE_W-1:0] d;
		r.mode  = EM_PLAIN;
		r.two   = 1'b0;
		r.words = {v[15:0], 16'h0000};
		r.chr   = v[7:0];
		d       = v - 21'h010000;
		if (v <= 21'd127) begin
			case (v[6:0])
				7'h09: begin r.mode = EM_ESC; r.chr = "t"; end
				7'h0A: begin r.mode = EM_ESC; r.chr = "n"; end
				7'h0D: begin r.mode = EM_ESC; r.chr = "r"; end
				7'h0C: begin r.mode = EM_ESC; r.chr = "f"; end
				7'h5C: begin r.mode = EM_ESC; r.chr = "\\"; end
				7'h2F: begin r.mode = EM_ESC; r.chr = "/"; end
				7'h22: begin r.mode = EM_ESC; r.chr = "\""; end
				default: begin
					if (v[6:0] < 7'h20 || v[6:0] == 7'h26 || v[6:0] == 7'h27 ||
						v[6:0] == 7'h3C || v[6:0] == 7'h3D || v[6:0] == 7'h3E ||
						v[6:0] == 7'h7F)
						r.mode = EM_UNI;
				end
			endcase
		end else if (v <= 21'h00FFFF) begin
			r.mode = EM_UNI;
		end else if (v <= 21'h10FFFF) begin
			r.mode  = EM_UNI;
			r.two   = 1'b1;
			r.words = {6'b110110, d[19:10], 6'b110111, d[9:0]};
		end else begin
			r.mode  = EM_UNI;
			r.words = {16'hFFFD, 16'h0000};
		end
		return r;
	endfunction

endpackage

// ===== rtl/utf8_json_string_escaper.sv =====
// UTF-8 to JSON string escaper: top level with the byte sequencer, the
// shared character emitter and the output stage. Depends on ujse_pkg.
//
// Usage:
//  s_axis carries one source byte per transaction: tdata = in_byte,
//  tuser = first_byte (opens a string, drops any unfinished sequence),
//  tlast = last_byte (flushes a pending sequence and closes the quote).
//  m_axis carries one escaped ASCII character per transaction; tlast marks
//  the final character caused by one input byte. A byte that only extends
//  a UTF-8 sequence produces nothing. cfg_we/cfg_wdata write add_quotes
//  (reset 1); write only while idle.
// Timing:
//  s_axis_tready is high only in the idle state, so a new byte is taken only
//  after the sequencer has finished the last one. Quotes ride in existing
//  steps. The shared emitter puts out one character per cycle; a low
//  m_axis_tready stalls the emitter; nothing is lost. Characters pass a
//  one-deep holding register into the output register.
// Reset: arst_n clears the sequence state and the output, sets add_quotes.
module utf8_json_string_escaper #(
	parameter int unsigned MAX_SEQUENCE_BYTES = ujse_pkg::MAX_SEQ_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tuser,   // [0] first_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_char
	output logic       m_axis_tlast,
	input  logic       cfg_we,
	input  logic       cfg_wdata       // add_quotes
);

	localparam int unsigned DEPTH = MAX_SEQUENCE_BYTES - 1;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = ujse_pkg::CNT_W;
	localparam int unsigned CODE_W = ujse_pkg::CODE_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_START  = 4'd1;
	localparam logic [3:0] ST_TAKE   = 4'd2;
	localparam logic [3:0] ST_NEWB   = 4'd3;
	localparam logic [3:0] ST_LASTCK = 4'd4;
	localparam logic [3:0] ST_FLUSH  = 4'd5;
	localparam logic [3:0] ST_EMIT   = 4'd6;
	localparam logic [3:0] ST_CLOSE  = 4'd7;
	localparam logic [3:0] ST_FINISH = 4'd8;

	logic [3:0]        state_q, ret_q, flush_ret_q;
	logic              add_quotes_q;
	logic [7:0]        byte_q;
	logic              first_q, last_q;
	logic [CNT_W-1:0]  pend_cnt_q, need_q, flush_i_q;
	logic [CODE_W-1:0] acc_q;
	logic [7:0]        pend_mem [DEPTH];

	ujse_pkg::emit_mode_t em_mode_q;
	logic              em_two_q;
	logic [31:0]       em_words_q;
	logic [7:0]        em_chr_q;
	logic [2:0]        em_pos_q;

	logic [7:0]        hold_q;
	logic              hold_v_q;
	logic [7:0]        out_q;
	logic              out_v_q, out_last_q;

	logic              out_free, can_put, put_en, fin_en, em_done;
	logic [7:0]        put_char, em_char;
	logic              is_cont, seq_done;
	logic [26:0]       acc_shift;
	logic [CODE_W-1:0] acc_upd, code_sel;
	logic [CNT_W-1:0]  lead_len;
	logic [7:0]        lead_mask;
	ujse_pkg::emit_load_t ld;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tlast  = out_last_q;

	assign out_free = !out_v_q || m_axis_tready;
	assign can_put  = !hold_v_q || out_free;

	// Continuation byte handling with saturation at the cap
	assign is_cont   = (byte_q[7:6] == 2'b10);
	assign acc_shift = {acc_q, byte_q[5:0]};
	always_comb begin
		if (acc_q < ujse_pkg::CODE_CAP) begin
			if (acc_shift > {6'd0, ujse_pkg::CODE_CAP})
				acc_upd = ujse_pkg::CODE_CAP;
			else
				acc_upd = acc_shift[CODE_W-1:0];
		end else begin
			acc_upd = acc_q;
		end
	end
	assign seq_done  = ({1'b0, pend_cnt_q} + 4'd1) >= {1'b0, need_q};
	assign lead_len  = ujse_pkg::seq_len(byte_q, MAX_SEQUENCE_BYTES);
	assign lead_mask = 8'hFF >> ({1'b0, lead_len} + 4'd1);

	always_comb begin
		unique case (state_q)
			ST_TAKE:  code_sel = acc_upd;
			ST_NEWB:  code_sel = {{(CODE_W-8){1'b0}}, byte_q};
			default:  code_sel = {{(CODE_W-8){1'b0}}, pend_mem[flush_i_q[IDX_W-1:0]]};
		endcase
	end
	assign ld = ujse_pkg::code_load(code_sel);

	// Character currently offered by the emitter
	always_comb begin
		em_char = em_chr_q;
		em_done = 1'b1;
		case (em_mode_q)
			ujse_pkg::EM_PLAIN: begin
				em_char = em_chr_q;
				em_done = 1'b1;
			end
			ujse_pkg::EM_ESC: begin
				em_char = (em_pos_q == 3'd0) ? "\\" : em_chr_q;
				em_done = (em_pos_q != 3'd0);
			end
			default: begin
				if (em_pos_q == 3'd0)
					em_char = "\\";
				else if (em_pos_q == 3'd1)
					em_char = "u";
				else
					em_char = ujse_pkg::hex_char(em_words_q[31:28]);
				em_done = (em_pos_q == 3'd5) && !em_two_q;
			end
		endcase
	end

	always_comb begin
		put_en   = 1'b0;
		put_char = "\"";
		unique case (state_q)
			ST_START: put_en = first_q && add_quotes_q && can_put;
			ST_CLOSE: put_en = add_quotes_q && can_put;
			ST_EMIT: begin
				put_en   = can_put;
				put_char = em_char;
			end
			default: put_en = 1'b0;
		endcase
	end
	assign fin_en = (state_q == ST_FINISH) && hold_v_q && out_free;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pend_cnt_q[IDX_W-1:0];
		if (state_q == ST_TAKE && pend_cnt_q != '0 && is_cont && !seq_done)
			mem_we = 1'b1;
		else if (state_q == ST_NEWB && lead_len > 3'd1) begin
			mem_we = 1'b1;
			mem_wa = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			pend_mem[mem_wa] <= byte_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_quotes_q <= 1'b1;
		end else if (cfg_we) begin
			add_quotes_q <= cfg_wdata;
		end
	end

	// Holding register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			hold_q     <= '0;
			out_q      <= '0;
			out_last_q <= 1'b0;
		end else if (put_en) begin
			hold_q   <= put_char;
			hold_v_q <= 1'b1;
			if (hold_v_q) begin
				out_q      <= hold_q;
				out_last_q <= 1'b0;
				out_v_q    <= 1'b1;
			end else begin
				out_v_q <= out_v_q && !m_axis_tready;
			end
		end else if (fin_en) begin
			out_q      <= hold_q;
			out_last_q <= 1'b1;
			out_v_q    <= 1'b1;
			hold_v_q   <= 1'b0;
		end else begin
			out_v_q <= out_v_q && !m_axis_tready;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			flush_ret_q <= ST_IDLE;
			byte_q      <= '0;
			first_q     <= 1'b0;
			last_q      <= 1'b0;
			pend_cnt_q  <= '0;
			need_q      <= '0;
			flush_i_q   <= '0;
			acc_q       <= '0;
			em_mode_q   <= ujse_pkg::EM_PLAIN;
			em_two_q    <= 1'b0;
			em_words_q  <= '0;
			em_chr_q    <= '0;
			em_pos_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						byte_q  <= s_axis_tdata;
						first_q <= s_axis_tuser;
						last_q  <= s_axis_tlast;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (!first_q) begin
						state_q <= ST_TAKE;
					end else if (!add_quotes_q || can_put) begin
						pend_cnt_q <= '0;
						need_q     <= '0;
						acc_q      <= '0;
						state_q    <= ST_TAKE;
					end
				end
				ST_TAKE: begin
					if (pend_cnt_q == '0) begin
						state_q <= ST_NEWB;
					end else if (!is_cont) begin
						flush_i_q   <= '0;
						flush_ret_q <= ST_NEWB;
						state_q     <= ST_FLUSH;
					end else if (seq_done) begin
						em_mode_q  <= ld.mode;
						em_two_q   <= ld.two;
						em_words_q <= ld.words;
						em_chr_q   <= ld.chr;
						em_pos_q   <= '0;
						pend_cnt_q <= '0;
						need_q     <= '0;
						acc_q      <= '0;
						ret_q      <= ST_LASTCK;
						state_q    <= ST_EMIT;
					end else begin
						acc_q      <= acc_upd;
						pend_cnt_q <= pend_cnt_q + 3'd1;
						state_q    <= ST_LASTCK;
					end
				end
				ST_NEWB: begin
					if (lead_len > 3'd1) begin
						pend_cnt_q <= 3'd1;
						need_q     <= lead_len;
						acc_q      <= {{(CODE_W-8){1'b0}}, byte_q & lead_mask};
						state_q    <= ST_LASTCK;
					end else begin
						em_mode_q  <= ld.mode;
						em_two_q   <= ld.two;
						em_words_q <= ld.words;
						em_chr_q   <= ld.chr;
						em_pos_q   <= '0;
						ret_q      <= ST_LASTCK;
						state_q    <= ST_EMIT;
					end
				end
				ST_LASTCK: begin
					if (last_q) begin
						flush_i_q   <= '0;
						flush_ret_q <= ST_CLOSE;
						state_q     <= ST_FLUSH;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FLUSH: begin
					if (flush_i_q < pend_cnt_q) begin
						em_mode_q  <= ld.mode;
						em_two_q   <= ld.two;
						em_words_q <= ld.words;
						em_chr_q   <= ld.chr;
						em_pos_q   <= '0;
						flush_i_q  <= flush_i_q + 3'd1;
						ret_q      <= ST_FLUSH;
						state_q    <= ST_EMIT;
					end else begin
						pend_cnt_q <= '0;
						need_q     <= '0;
						acc_q      <= '0;
						state_q    <= flush_ret_q;
					end
				end
				ST_EMIT: begin
					if (can_put) begin
						if (em_done) begin
							state_q <= ret_q;
						end else if (em_mode_q == ujse_pkg::EM_UNI && em_pos_q == 3'd5) begin
							// low surrogate now sits in the top half
							em_two_q   <= 1'b0;
							em_pos_q   <= '0;
							em_words_q <= {em_words_q[27:0], 4'd0};
						end else begin
							em_pos_q <= em_pos_q + 3'd1;
							if (em_pos_q >= 3'd2)
								em_words_q <= {em_words_q[27:0], 4'd0};
						end
					end
				end
				ST_CLOSE: begin
					if (!add_quotes_q || can_put)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!hold_v_q || out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_need: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_cnt_q == '0) == (need_q == '0))
		else $error("pending count and sequence length disagree");

	a_cnt_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_cnt_q != '0) |-> (pend_cnt_q < need_q && int'(pend_cnt_q) <= DEPTH))
		else $error("pending count out of range");

	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_v_q)
		else $error("character left in holding register when idle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("sequencer accepted a byte while busy");
`endif

endmodule
